/* rtl/circular_angle_rms_distance_assert.svh */
// Assertion macros used by the circular RMS angle distance checker.
`ifndef CIRCULAR_ANGLE_RMS_DISTANCE_ASSERT_SVH
`define CIRCULAR_ANGLE_RMS_DISTANCE_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define CAD_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// A condition that must hold in the cycle after a trigger, outside reset.
`define CAD_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("assertion failed");

// A condition that must hold in the cycle after reset is seen.
`define CAD_ASSERT_RESET(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) !rst_n |=> (cond)) \
    else $error("assertion failed");

`endif

/* rtl/cad_pkg.sv */
// Package with constants and controller/datapath interface types.
`default_nettype none
package cad_pkg;

  localparam int ANGLE_W         = 15;
  localparam int ANGLE_FRAC_BITS = 12;
  localparam int DIFF_W          = 16;
  localparam int D_W             = 14;
  localparam int SQ_W            = 2 * D_W;
  localparam int SUM_W           = 38;
  localparam int CNT_W           = 11;
  localparam int ROOT_W          = SUM_W / 2;
  localparam int SREM_W          = ROOT_W + 2;
  localparam int RMS_W           = 14;
  localparam int MAX_ANGLES      = 1024;

  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int ITER_W     = $clog2(DIV_STEPS);

  localparam int IN_TDATA_W  = ((2 * ANGLE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((RMS_W + CNT_W + 7) / 8) * 8;

  // pi and 2*pi in the angle format, rounded from a Q32 value of pi.
  localparam longint unsigned PI_Q32 = 64'd13493037705;
  localparam logic [DIFF_W-1:0] PI_FX = DIFF_W'(
    (PI_Q32 + (64'd1 << (31 - ANGLE_FRAC_BITS))) >> (32 - ANGLE_FRAC_BITS));
  localparam logic [DIFF_W-1:0] TWO_PI_FX = DIFF_W'(
    (2 * PI_Q32 + (64'd1 << (31 - ANGLE_FRAC_BITS))) >> (32 - ANGLE_FRAC_BITS));

  typedef struct packed {
    logic accept;
    logic start_div;
    logic div_step;
    logic sqrt_step;
    logic load_out;
  } cad_cmd_t;

  typedef struct packed {
    logic div_last;
    logic sqrt_last;
    logic out_free;
  } cad_sts_t;

endpackage
`default_nettype wire

/* rtl/cad_ctrl.sv */
// Controller state machine: accumulate, divide, square root, hand off.
`default_nettype none
module cad_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  input  wire               in_tlast,
  input  cad_pkg::cad_sts_t sts,
  output logic              in_tready,
  output cad_pkg::cad_cmd_t cmd
);
  import cad_pkg::*;

  localparam logic [2:0] ST_ACC   = 3'd0;
  localparam logic [2:0] ST_FLUSH = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_SQRT  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_ACC: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid && in_tlast) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd.start_div = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_ACC;
        end
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/cad_datapath.sv */
// Datapath: wrapped difference, square accumulation, divider, square root.
`default_nettype none
module cad_datapath (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire  [cad_pkg::ANGLE_W-1:0]    angle_first,
  input  wire  [cad_pkg::ANGLE_W-1:0]    angle_second,
  input  cad_pkg::cad_cmd_t              cmd,
  input  wire                            out_tready,
  output cad_pkg::cad_sts_t              sts,
  output logic                           out_tvalid,
  output logic [cad_pkg::RMS_W-1:0]      rms_distance,
  output logic [cad_pkg::CNT_W-1:0]      angle_count,
  output logic                           overflow
);
  import cad_pkg::*;

  logic signed [DIFF_W-1:0] sdiff;
  logic        [DIFF_W-1:0] adiff;
  logic        [D_W-1:0]    dwrap;

  logic [SQ_W-1:0]   sq_r, sq_nxt;
  logic              sq_v_r, sq_v_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt, sum_add;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;

  logic [CNT_W-1:0]  divisor_r, divisor_nxt;
  logic              res_ovf_r, res_ovf_nxt;
  logic [CNT_W-1:0]  drem_r, drem_nxt;
  logic [SUM_W-1:0]  q_r, q_nxt;
  logic [CNT_W:0]    dtrial;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [SREM_W-1:0] srem_r, srem_nxt, sshift;
  logic [SREM_W:0]   strial;
  logic [ITER_W-1:0] iter_r, iter_nxt;

  logic              oval_r, oval_nxt;
  logic [RMS_W-1:0]  orms_r, orms_nxt;
  logic [CNT_W-1:0]  ocnt_r, ocnt_nxt;
  logic              oovf_r, oovf_nxt;

  // Absolute difference, folded into [0, pi]; beyond 2*pi it saturates to zero.
  always_comb begin
    sdiff = DIFF_W'($signed(angle_second)) - DIFF_W'($signed(angle_first));
    adiff = sdiff[DIFF_W-1] ? DIFF_W'(-sdiff) : DIFF_W'(sdiff);
    if (adiff > PI_FX) begin
      dwrap = (adiff > TWO_PI_FX) ? '0 : D_W'(TWO_PI_FX - adiff);
    end else begin
      dwrap = D_W'(adiff);
    end
  end

  assign sum_add = sum_r + (sq_v_r ? SUM_W'(sq_r) : '0);

  always_comb begin
    sq_nxt      = sq_r;
    sq_v_nxt    = 1'b0;
    sum_nxt     = sum_add;
    cnt_nxt     = cnt_r;
    ovf_nxt     = ovf_r;
    divisor_nxt = divisor_r;
    res_ovf_nxt = res_ovf_r;
    drem_nxt    = drem_r;
    q_nxt       = q_r;
    root_nxt    = root_r;
    srem_nxt    = srem_r;
    iter_nxt    = iter_r;
    dtrial      = {drem_r, q_r[SUM_W-1]} - {1'b0, divisor_r};
    sshift      = {srem_r[SREM_W-3:0], q_r[SUM_W-1:SUM_W-2]};
    strial      = {1'b0, sshift} - {1'b0, root_r, 2'b01};

    if (cmd.accept) begin
      if (cnt_r != CNT_W'(MAX_ANGLES)) begin
        sq_nxt   = SQ_W'(dwrap) * SQ_W'(dwrap);
        sq_v_nxt = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    if (cmd.start_div) begin
      q_nxt       = sum_add;
      divisor_nxt = cnt_r;
      res_ovf_nxt = ovf_r;
      drem_nxt    = '0;
      root_nxt    = '0;
      srem_nxt    = '0;
      iter_nxt    = '0;
      sum_nxt     = '0;
      cnt_nxt     = '0;
      ovf_nxt     = 1'b0;
    end

    // Restoring division, one quotient bit per cycle.
    if (cmd.div_step) begin
      if (!dtrial[CNT_W]) begin
        drem_nxt = dtrial[CNT_W-1:0];
      end else begin
        drem_nxt = {drem_r[CNT_W-2:0], q_r[SUM_W-1]};
      end
      q_nxt    = {q_r[SUM_W-2:0], ~dtrial[CNT_W]};
      iter_nxt = sts.div_last ? '0 : iter_r + 1'b1;
    end

    // Digit-by-digit square root, two radicand bits per cycle.
    if (cmd.sqrt_step) begin
      if (!strial[SREM_W]) begin
        srem_nxt = strial[SREM_W-1:0];
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        srem_nxt = sshift;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      q_nxt    = {q_r[SUM_W-3:0], 2'b00};
      iter_nxt = iter_r + 1'b1;
    end
  end

  assign sts.div_last  = (iter_r == ITER_W'(DIV_STEPS - 1));
  assign sts.sqrt_last = (iter_r == ITER_W'(SQRT_STEPS - 1));
  assign sts.out_free  = !oval_r || out_tready;

  always_comb begin
    oval_nxt = oval_r;
    orms_nxt = orms_r;
    ocnt_nxt = ocnt_r;
    oovf_nxt = oovf_r;
    if (out_tready) begin
      oval_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      oval_nxt = 1'b1;
      orms_nxt = root_r[RMS_W-1:0];
      ocnt_nxt = divisor_r;
      oovf_nxt = res_ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
      sum_r  <= '0;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      iter_r <= '0;
      oval_r <= 1'b0;
    end else begin
      sq_v_r <= sq_v_nxt;
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
      iter_r <= iter_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sq_r      <= sq_nxt;
    divisor_r <= divisor_nxt;
    res_ovf_r <= res_ovf_nxt;
    drem_r    <= drem_nxt;
    q_r       <= q_nxt;
    root_r    <= root_nxt;
    srem_r    <= srem_nxt;
    orms_r    <= orms_nxt;
    ocnt_r    <= ocnt_nxt;
    oovf_r    <= oovf_nxt;
  end

  assign out_tvalid   = oval_r;
  assign rms_distance = orms_r;
  assign angle_count  = ocnt_r;
  assign overflow     = oovf_r;

endmodule
`default_nettype wire

/* rtl/circular_angle_rms_distance.sv */
// Top level of the circular RMS torsion angle distance block.
//
// The input channel carries one pair of torsion angles per transfer, both in
// signed Q3.12 radians, with tlast marking the final pair of a set. Pairs are
// taken one per cycle while the block accumulates: each wrapped difference is
// squared into a register and added into the running sum in the cycle after.
// When the last pair is taken, the input stalls while the block closes the
// sum, runs the bit-serial divider that forms the mean and the digit-serial
// square root, and loads the output register.
// The result carries the RMS distance, the pair count and an overflow flag
// that reports pairs beyond the maximum count, which were dropped.
// If the receiver stalls, the result holds in the output register; the block
// goes on accepting pairs of the next set and only waits if a new result is
// ready before the previous one has been taken.
// A synchronous active-low reset clears the sum, the count, the flag and any
// pending result.
`default_nettype none
module circular_angle_rms_distance (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // angle_first [14:0], angle_second [29:15], zero fill above.
  input  wire  [cad_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire                              in_tlast,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // rms_distance [13:0], angle_count [24:14], zero fill above.
  output logic [cad_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // overflow [0].
  output logic                             out_tuser
);
  import cad_pkg::*;

  cad_cmd_t          cmd;
  cad_sts_t          sts;
  logic [RMS_W-1:0]  rms_distance;
  logic [CNT_W-1:0]  angle_count;

  // The controller sequences accumulation, division, square root and handoff.
  cad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .sts       (sts),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  // The datapath holds the sum, count, iterative units and output register.
  cad_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .angle_first  (in_tdata[ANGLE_W-1:0]),
    .angle_second (in_tdata[2*ANGLE_W-1:ANGLE_W]),
    .cmd          (cmd),
    .out_tready   (out_tready),
    .sts          (sts),
    .out_tvalid   (out_tvalid),
    .rms_distance (rms_distance),
    .angle_count  (angle_count),
    .overflow     (out_tuser)
  );

  // Pack the result fields, lowest field first, zeros above.
  assign out_tdata = OUT_TDATA_W'({angle_count, rms_distance});

endmodule
`default_nettype wire

/* rtl/cad_checker.sv */
// Port-level checker for the circular RMS angle distance block, with its bind.
`default_nettype none
`include "circular_angle_rms_distance_assert.svh"
module cad_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [cad_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input wire                              out_tuser
);
  import cad_pkg::*;

  logic [RMS_W-1:0] rms_w;
  logic [CNT_W-1:0] cnt_w;

  assign rms_w = out_tdata[RMS_W-1:0];
  assign cnt_w = out_tdata[RMS_W+CNT_W-1:RMS_W];

  `CAD_ASSERT_RESET(a_reset_no_result, clk, rst_n, !out_tvalid)
  `CAD_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `CAD_ASSERT_ALWAYS(a_count_range, clk, rst_n,
    !out_tvalid || (cnt_w != '0 && cnt_w <= CNT_W'(MAX_ANGLES)))
  `CAD_ASSERT_ALWAYS(a_rms_range, clk, rst_n,
    !out_tvalid || (RMS_W'(rms_w) <= RMS_W'(PI_FX)))

endmodule

bind circular_angle_rms_distance cad_checker u_cad_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the circular RMS torsion angle distance block.
module testbench;

  // pi and 2*pi in Q3.12 radians, rounded from pi in Q32.
  localparam int HALF_TURN = 12868;
  localparam int FULL_TURN = 25736;
  // Largest legal angle magnitude, and the most pairs a set can accumulate.
  localparam int ANGLE_MAX = 12868;
  localparam int MAX_PAIRS = 1024;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_PRINTED = 30;

  typedef logic signed [14:0] angle_t;

  typedef struct packed {
    logic [13:0] rms;
    logic [10:0] count;
    logic        overflow;
  } rms_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [cad_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            in_tlast = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [cad_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tuser;

  // Predicted state of the block: the running sum, the pair count and the
  // flag that records dropped pairs, for the set now being accumulated.
  longint unsigned sum_sq = 0;
  int unsigned     pairs_in_set = 0;
  bit              set_overflowed = 1'b0;
  rms_result_t     rms_results[$];

  // Idling control. The percentages and the hold request are only changed
  // just after a rising edge, so the ready driver never races with them.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;

  int error_count = 0;
  int pairs_sent = 0;
  int results_checked = 0;
  int overflow_results = 0;
  int cycle_count = 0;

  always #5 clk = ~clk;

  circular_angle_rms_distance i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Integer floor square root, built one result bit at a time from the top.
  function automatic longint unsigned floor_sqrt(input longint unsigned value);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= value) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // Folds one accepted pair into the predicted state. On the last pair of a
  // set the expected result is queued and the state starts over.
  function automatic void accumulate_pair(input angle_t first, input angle_t second,
                                          input logic last);
    int              diff;
    longint unsigned wrapped;
    longint unsigned mean;
    rms_result_t     result;
    diff = int'(second) - int'(first);
    if (diff < 0) begin
      diff = -diff;
    end
    wrapped = diff;
    // Past pi the short way round is 2*pi - d; past 2*pi that would go
    // negative, so the difference saturates at zero.
    if (wrapped > HALF_TURN) begin
      wrapped = (wrapped > FULL_TURN) ? 0 : FULL_TURN - wrapped;
    end
    if (pairs_in_set >= MAX_PAIRS) begin
      set_overflowed = 1'b1;
    end else begin
      sum_sq += wrapped * wrapped;
      pairs_in_set++;
    end
    if (last) begin
      mean = (pairs_in_set != 0) ? sum_sq / pairs_in_set : 0;
      result.rms = 14'(floor_sqrt(mean));
      result.count = 11'(pairs_in_set);
      result.overflow = set_overflowed;
      rms_results.push_back(result);
      sum_sq = 0;
      pairs_in_set = 0;
      set_overflowed = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // Offers one pair on the input channel and waits for the transfer. Each
  // cycle before the offer, the sender idles with the set percentage.
  // Entered and left just after a falling edge. The valid is left high so
  // that back-to-back pairs keep the channel busy.
  task automatic send_pair(input angle_t first, input angle_t second, input logic last);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, second, first};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    // The prediction is queued on the falling edge, so it can never be
    // matched against a result sampled at the edge of its own transfer.
    accumulate_pair(first, second, last);
    pairs_sent++;
  endtask

  // Drops the input valid and waits until every predicted result is in.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (rms_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    @(negedge clk);
  endtask

  // Mostly legal angles, with the extremes and a few raw 15-bit patterns
  // that may lie outside plus or minus pi.
  function automatic angle_t random_angle();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 6) begin
      return angle_t'($urandom());
    end
    if (pick < 10) begin
      return angle_t'(ANGLE_MAX);
    end
    if (pick < 14) begin
      return angle_t'(-ANGLE_MAX);
    end
    return angle_t'(int'($urandom_range(2 * ANGLE_MAX, 0)) - ANGLE_MAX);
  endfunction

  // Single-pair sets at the wrap boundaries, then short mixed sets.
  task automatic test_directed_cases();
    send_pair(0, 0, 1'b1);
    send_pair(-6434, 6434, 1'b1);            // exactly pi, no wrap
    send_pair(6434, -6435, 1'b1);            // one past pi wraps to pi - 1
    send_pair(-ANGLE_MAX, ANGLE_MAX, 1'b1);  // exactly 2*pi wraps to zero
    send_pair(ANGLE_MAX, 1 - ANGLE_MAX, 1'b1);
    send_pair(-16384, 16383, 1'b1);          // beyond 2*pi saturates to zero
    send_pair(16383, -16384, 1'b1);
    send_pair(16383, 0, 1'b1);
    send_pair(-16384, -16384, 1'b1);
    send_pair(ANGLE_MAX, ANGLE_MAX, 1'b1);
    // A mixed set whose mean truncates.
    send_pair(ANGLE_MAX, ANGLE_MAX, 1'b0);
    send_pair(-ANGLE_MAX, 0, 1'b0);
    send_pair(100, -3000, 1'b0);
    send_pair(1, 2, 1'b1);
    // A set that mixes a saturated difference with pi differences.
    send_pair(-16384, 16383, 1'b0);
    send_pair(0, ANGLE_MAX, 1'b0);
    send_pair(ANGLE_MAX, 0, 1'b1);
    send_pair(-7, 5, 1'b0);
    send_pair(3, 3, 1'b1);
  endtask

  // A set that runs past the pair limit, its last pair among the dropped
  // ones, then a one-pair set to show that the flag has been cleared.
  task automatic test_count_limit();
    for (int i = 0; i < MAX_PAIRS + 2; i++) begin
      if (i < MAX_PAIRS - 4) begin
        if ($urandom_range(1, 0) != 0) begin
          send_pair(-6434, 6434, 1'b0);
        end else begin
          send_pair(6434, -6434, 1'b0);
        end
      end else begin
        send_pair(random_angle(), random_angle(), i == MAX_PAIRS + 1);
      end
    end
    send_pair(0, 100, 1'b1);
  endtask

  // Random sets, mostly short, now and then long, with near-equal pairs.
  task automatic test_random_sets(input int send_pct, input int recv_pct,
                                  input int pair_budget);
    int     set_len;
    int     sent;
    angle_t first;
    angle_t second;
    set_idling(send_pct, recv_pct);
    sent = 0;
    while (sent < pair_budget) begin
      set_len = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 10) : $urandom_range(6, 1);
      for (int i = 0; i < set_len; i++) begin
        first = random_angle();
        if ($urandom_range(2, 0) == 0) begin
          second = angle_t'(int'(first) + int'($urandom_range(400, 0)) - 200);
        end else begin
          second = random_angle();
        end
        send_pair(first, second, i == set_len - 1);
      end
      sent += set_len;
    end
  endtask

  // The receiver holds off for a long stretch while short sets keep coming,
  // so a finished result waits in the output register and the next one
  // stalls the input.
  task automatic test_output_backpressure();
    @(posedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = HOLD_CYCLES;
    @(negedge clk);
    for (int s = 0; s < 8; s++) begin
      for (int i = 0; i < 3; i++) begin
        send_pair(random_angle(), random_angle(), i == 2);
      end
    end
  endtask

  // Ready driver: random stalls, or a counted hold when one is requested.
  initial begin : drive_ready
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  // Each result transfer is compared with the oldest predicted result.
  always @(posedge clk) begin : check_results
    rms_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (rms_results.size() == 0) begin
        report_mismatch("result with none expected, rms_distance", out_tdata[13:0], 0);
      end else begin
        want = rms_results.pop_front();
        if (out_tdata[13:0] !== want.rms) begin
          report_mismatch("rms_distance", out_tdata[13:0], want.rms);
        end
        if (out_tdata[24:14] !== want.count) begin
          report_mismatch("angle_count", out_tdata[24:14], want.count);
        end
        if (out_tuser !== want.overflow) begin
          report_mismatch("overflow", out_tuser, want.overflow);
        end
        if (want.overflow) begin
          overflow_results++;
        end
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : run_tests
    // Reset is held low from the start and released on a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_cases();
    test_count_limit();
    test_random_sets(34, 53, 150);
    test_random_sets(53, 34, 150);
    test_random_sets(0, 0, 150);
    test_output_backpressure();

    wait_for_results();
    // Let any stray result surface before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d angle pairs; checked %0d results, %0d of them past the pair limit.",
             pairs_sent, results_checked, overflow_results);
    $display("Idling covered busy sender, busy receiver, none, and a %0d-cycle output hold.",
             HOLD_CYCLES);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
